>>> hw/rtl/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: field widths,
// command and character codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int CMD_W   = 2;
  localparam int CH_W    = 8;
  localparam int TERM_W  = 2;
  localparam int IDX_W   = 11;
  localparam int ATTR_W  = 8;
  localparam int POS_W   = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SHOWN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTR  = 1'b1;

  localparam logic [CH_W-1:0] CH_NUL = 8'h00;
  localparam logic [CH_W-1:0] CH_BS  = 8'h08;
  localparam logic [CH_W-1:0] CH_LF  = 8'h0a;
  localparam logic [CH_W-1:0] CH_CR  = 8'h0d;
  localparam logic [CH_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOAD,
    OP_NEWLINE,
    OP_SCROLL_INIT,
    OP_SCROLL,
    OP_BACK,
    OP_ADDR_CELL,
    OP_ADDR_READ,
    OP_PUT,
    OP_BLANK_CHAR,
    OP_READ,
    OP_CAPTURE,
    OP_CLEAR_INIT,
    OP_CLEAR,
    OP_INIT,
    OP_WB,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic cmd_put;
    logic cmd_read;
    logic cmd_clear;
    logic t_ok;
    logic idx_ok;
    logic shown_ok;
    logic ch_nul;
    logic ch_nl;
    logic ch_bs;
    logic col_full;
    logic row_last;
    logic at_home;
    logic scroll_last;
    logic clear_last;
    logic init_last;
  } dp_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/tcw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the text console writer: steps one item through cursor load,
// newline/scroll, cell write, cell read or clear, and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire tcw_pkg::dp_status_t st,
  output tcw_pkg::dp_cmd_t        cmd
);

  typedef enum logic [17:0] {
    ST_INIT        = 18'h00001,
    ST_IDLE        = 18'h00002,
    ST_LOAD        = 18'h00004,
    ST_DECIDE      = 18'h00008,
    ST_NEWLINE     = 18'h00010,
    ST_SCROLL_INIT = 18'h00020,
    ST_SCROLL      = 18'h00040,
    ST_BACK        = 18'h00080,
    ST_ADDR        = 18'h00100,
    ST_PUT         = 18'h00200,
    ST_BLANK       = 18'h00400,
    ST_ADDR_READ   = 18'h00800,
    ST_READ        = 18'h01000,
    ST_CAPTURE     = 18'h02000,
    ST_CLEAR_INIT  = 18'h04000,
    ST_CLEAR       = 18'h08000,
    ST_WB          = 18'h10000,
    ST_RESULT      = 18'h20000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   printable;
  logic   slot_free;

  assign printable = !st.ch_nul && !st.ch_nl && !st.ch_bs;
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = tcw_pkg::OP_NONE;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_INIT: begin
        cmd.op = tcw_pkg::OP_INIT;
        if (st.init_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = tcw_pkg::OP_ACCEPT;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.op    = tcw_pkg::OP_LOAD;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (st.cmd_put) begin
          if (!st.t_ok || st.ch_nul) state_nxt = ST_RESULT;
          else if (st.ch_nl)         state_nxt = ST_NEWLINE;
          else if (st.ch_bs)         state_nxt = st.at_home ? ST_RESULT : ST_BACK;
          else if (st.col_full)      state_nxt = ST_NEWLINE;
          else                       state_nxt = ST_ADDR;
        end else if (st.cmd_read) begin
          state_nxt = (st.t_ok && st.idx_ok) ? ST_ADDR_READ : ST_RESULT;
        end else if (st.cmd_clear) begin
          state_nxt = st.shown_ok ? ST_CLEAR_INIT : ST_RESULT;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_NEWLINE: begin
        cmd.op = tcw_pkg::OP_NEWLINE;
        if (st.row_last)     state_nxt = ST_SCROLL_INIT;
        else if (printable)  state_nxt = ST_ADDR;
        else                 state_nxt = ST_WB;
      end
      ST_SCROLL_INIT: begin
        cmd.op    = tcw_pkg::OP_SCROLL_INIT;
        state_nxt = ST_SCROLL;
      end
      ST_SCROLL: begin
        cmd.op = tcw_pkg::OP_SCROLL;
        if (st.scroll_last) state_nxt = printable ? ST_ADDR : ST_WB;
      end
      ST_BACK: begin
        cmd.op    = tcw_pkg::OP_BACK;
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.op    = tcw_pkg::OP_ADDR_CELL;
        state_nxt = st.ch_bs ? ST_BLANK : ST_PUT;
      end
      ST_PUT: begin
        cmd.op    = tcw_pkg::OP_PUT;
        state_nxt = ST_WB;
      end
      ST_BLANK: begin
        cmd.op    = tcw_pkg::OP_BLANK_CHAR;
        state_nxt = ST_WB;
      end
      ST_ADDR_READ: begin
        cmd.op    = tcw_pkg::OP_ADDR_READ;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.op    = tcw_pkg::OP_READ;
        state_nxt = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        cmd.op    = tcw_pkg::OP_CAPTURE;
        state_nxt = ST_RESULT;
      end
      ST_CLEAR_INIT: begin
        cmd.op    = tcw_pkg::OP_CLEAR_INIT;
        state_nxt = ST_CLEAR;
      end
      ST_CLEAR: begin
        cmd.op = tcw_pkg::OP_CLEAR;
        if (st.clear_last) state_nxt = ST_WB;
      end
      ST_WB: begin
        cmd.op    = tcw_pkg::OP_WB;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free) begin
          cmd.op        = tcw_pkg::OP_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/tcw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen store, per-terminal cursors, configuration registers, sweep
// pointers and the result register of the text console writer.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TERMINALS = 3
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire tcw_pkg::dp_cmd_t                    cmd,
  output tcw_pkg::dp_status_t                      st,
  input  wire logic [tcw_pkg::CMD_W-1:0]           in_cmd,
  input  wire logic [tcw_pkg::CH_W-1:0]            in_ch,
  input  wire logic [tcw_pkg::TERM_W-1:0]          in_target_terminal,
  input  wire logic [tcw_pkg::IDX_W-1:0]           in_cell_index,
  input  wire logic                                cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic [tcw_pkg::CH_W-1:0]                 out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]               out_cell_attr,
  output logic [tcw_pkg::POS_W-1:0]                out_cursor_pos,
  output logic                                     out_scrolled
);

  localparam int SCREEN = ROWS * COLUMNS;
  localparam int STORE  = TERMINALS * SCREEN;
  localparam int COPY   = (ROWS - 1) * COLUMNS;
  localparam int AW     = $clog2(STORE);
  localparam int CNTW   = $clog2(SCREEN + 1);
  localparam int CW     = $clog2(COLUMNS + 1);
  localparam int RW     = $clog2(ROWS);
  localparam int PW     = $clog2(SCREEN + 1);
  localparam int TW     = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
  localparam int TNW    = (TW > tcw_pkg::TERM_W) ? TW : tcw_pkg::TERM_W;

  // screen store
  logic [tcw_pkg::CH_W-1:0]   char_mem [STORE];
  logic [tcw_pkg::ATTR_W-1:0] attr_mem [STORE];

  // cursors
  logic [CW-1:0] cur_col_r [TERMINALS];
  logic [RW-1:0] cur_row_r [TERMINALS];

  // config
  logic [tcw_pkg::TERM_W-1:0] shown_r;
  logic [tcw_pkg::ATTR_W-1:0] attr_r;

  // item and working registers
  logic [tcw_pkg::CMD_W-1:0]  cmd_r;
  logic [tcw_pkg::CH_W-1:0]   ch_r;
  logic [TNW-1:0]             t_r;
  logic [tcw_pkg::IDX_W-1:0]  idx_r;
  logic [TNW-1:0]             term_r;
  logic [CW-1:0]              col_r;
  logic [RW-1:0]              row_r;
  logic [AW-1:0]              base_r;
  logic [AW-1:0]              addr_r;
  logic [AW-1:0]              wr_ptr_r;
  logic [AW-1:0]              rd_ptr_r;
  logic [CNTW-1:0]            cnt_r;
  logic                       scr_r;
  logic [tcw_pkg::CH_W-1:0]   rchar_r;
  logic [tcw_pkg::ATTR_W-1:0] rattr_r;
  logic [tcw_pkg::CH_W-1:0]   rd_char_r;
  logic [tcw_pkg::ATTR_W-1:0] rd_attr_r;

  // result register
  logic [tcw_pkg::CH_W-1:0]   res_char_r;
  logic [tcw_pkg::ATTR_W-1:0] res_attr_r;
  logic [tcw_pkg::POS_W-1:0]  res_pos_r;
  logic                       res_scr_r;

  // memory port controls
  logic                       we_char, we_attr;
  logic [AW-1:0]              wr_addr;
  logic [tcw_pkg::CH_W-1:0]   wr_char;
  logic [tcw_pkg::ATTR_W-1:0] wr_attr;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;

  logic [TNW-1:0]             cur_sel;
  logic [TNW-1:0]             shown_ext;
  logic [PW-1:0]              pos_full;
  logic                       copy_ok;
  logic                       shown_ok;

  assign shown_ext = TNW'(shown_r);
  assign shown_ok  = int'(shown_r) < TERMINALS;
  assign cur_sel   = (cmd.op == tcw_pkg::OP_RESULT) ? shown_ext : t_r;
  assign pos_full  = PW'(cur_row_r[cur_sel[TW-1:0]]) * PW'(COLUMNS)
                   + PW'(cur_col_r[cur_sel[TW-1:0]]);
  assign copy_ok   = cnt_r <= CNTW'(COPY);

  always_comb begin
    st.cmd_put     = (cmd_r == tcw_pkg::CMD_PUT);
    st.cmd_read    = (cmd_r == tcw_pkg::CMD_READ);
    st.cmd_clear   = (cmd_r == tcw_pkg::CMD_CLEAR);
    st.t_ok        = int'(t_r) < TERMINALS;
    st.idx_ok      = int'(idx_r) < SCREEN;
    st.shown_ok    = shown_ok;
    st.ch_nul      = (ch_r == tcw_pkg::CH_NUL);
    st.ch_nl       = (ch_r == tcw_pkg::CH_LF) || (ch_r == tcw_pkg::CH_CR);
    st.ch_bs       = (ch_r == tcw_pkg::CH_BS);
    st.col_full    = (col_r == CW'(COLUMNS));
    st.row_last    = (row_r == RW'(ROWS - 1));
    st.at_home     = (col_r == '0) && (row_r == '0);
    st.scroll_last = (cnt_r == CNTW'(SCREEN));
    st.clear_last  = (cnt_r == CNTW'(SCREEN - 1));
    st.init_last   = (wr_ptr_r == AW'(STORE - 1));
  end

  // memory port selection
  always_comb begin
    we_char = 1'b0;
    we_attr = 1'b0;
    wr_addr = wr_ptr_r;
    wr_char = tcw_pkg::BLANK_CHAR;
    wr_attr = attr_r;
    rd_en   = 1'b0;
    rd_addr = addr_r;
    case (cmd.op)
      tcw_pkg::OP_INIT: begin
        we_char = 1'b1;
        we_attr = 1'b1;
        wr_attr = tcw_pkg::RESET_ATTR;
      end
      tcw_pkg::OP_CLEAR: begin
        we_char = 1'b1;
        we_attr = 1'b1;
      end
      tcw_pkg::OP_SCROLL: begin
        rd_addr = rd_ptr_r;
        rd_en   = cnt_r < CNTW'(COPY);
        we_char = (cnt_r != '0);
        we_attr = (cnt_r != '0);
        if (copy_ok) begin
          wr_char = rd_char_r;
          wr_attr = rd_attr_r;
        end
      end
      tcw_pkg::OP_PUT: begin
        we_char = 1'b1;
        we_attr = 1'b1;
        wr_addr = addr_r;
        wr_char = ch_r;
      end
      tcw_pkg::OP_BLANK_CHAR: begin
        we_char = 1'b1;
        wr_addr = addr_r;
      end
      tcw_pkg::OP_READ: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_char) char_mem[wr_addr] <= wr_char;
    if (we_attr) attr_mem[wr_addr] <= wr_attr;
    if (rd_en) begin
      rd_char_r <= char_mem[rd_addr];
      rd_attr_r <= attr_mem[rd_addr];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r <= '0;
      attr_r  <= tcw_pkg::RESET_ATTR;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tcw_pkg::REG_SHOWN: shown_r <= cfg_wdata[tcw_pkg::TERM_W-1:0];
        tcw_pkg::REG_ATTR:  attr_r  <= cfg_wdata[tcw_pkg::ATTR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // cursors and sweep pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TERMINALS; i++) begin
        cur_col_r[i] <= '0;
        cur_row_r[i] <= '0;
      end
      wr_ptr_r <= '0;
    end else begin
      if (cmd.op == tcw_pkg::OP_WB) begin
        cur_col_r[term_r[TW-1:0]] <= col_r;
        cur_row_r[term_r[TW-1:0]] <= row_r;
      end
      if (we_char && (cmd.op != tcw_pkg::OP_PUT) && (cmd.op != tcw_pkg::OP_BLANK_CHAR))
        wr_ptr_r <= wr_ptr_r + AW'(1);
      else if (cmd.op == tcw_pkg::OP_SCROLL_INIT)
        wr_ptr_r <= base_r;
      else if (cmd.op == tcw_pkg::OP_CLEAR_INIT)
        wr_ptr_r <= AW'(shown_ext) * AW'(SCREEN);
    end
  end

  // item and working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      tcw_pkg::OP_ACCEPT: begin
        cmd_r   <= in_cmd;
        ch_r    <= in_ch;
        t_r     <= TNW'(in_target_terminal);
        idx_r   <= in_cell_index;
        scr_r   <= 1'b0;
        rchar_r <= '0;
        rattr_r <= '0;
      end
      tcw_pkg::OP_LOAD: begin
        col_r  <= cur_col_r[t_r[TW-1:0]];
        row_r  <= cur_row_r[t_r[TW-1:0]];
        term_r <= t_r;
        base_r <= AW'(t_r) * AW'(SCREEN);
      end
      tcw_pkg::OP_NEWLINE: begin
        col_r <= '0;
        if (row_r != RW'(ROWS - 1)) row_r <= row_r + RW'(1);
      end
      tcw_pkg::OP_SCROLL_INIT: begin
        scr_r    <= 1'b1;
        rd_ptr_r <= base_r + AW'(COLUMNS);
        cnt_r    <= '0;
      end
      tcw_pkg::OP_SCROLL: begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
        cnt_r    <= cnt_r + CNTW'(1);
      end
      tcw_pkg::OP_BACK: begin
        if (col_r == '0) begin
          row_r <= row_r - RW'(1);
          col_r <= CW'(COLUMNS - 1);
        end else begin
          col_r <= col_r - CW'(1);
        end
      end
      tcw_pkg::OP_ADDR_CELL: begin
        addr_r <= base_r + AW'(row_r) * AW'(COLUMNS) + AW'(col_r);
      end
      tcw_pkg::OP_ADDR_READ: begin
        addr_r <= base_r + AW'(idx_r);
      end
      tcw_pkg::OP_PUT: begin
        col_r <= col_r + CW'(1);
      end
      tcw_pkg::OP_CAPTURE: begin
        rchar_r <= rd_char_r;
        rattr_r <= rd_attr_r;
      end
      tcw_pkg::OP_CLEAR_INIT: begin
        term_r <= shown_ext;
        col_r  <= '0;
        row_r  <= '0;
        cnt_r  <= '0;
      end
      tcw_pkg::OP_CLEAR: begin
        cnt_r <= cnt_r + CNTW'(1);
      end
      tcw_pkg::OP_RESULT: begin
        res_char_r <= rchar_r;
        res_attr_r <= rattr_r;
        res_pos_r  <= shown_ok ? tcw_pkg::POS_W'(pos_full) : '0;
        res_scr_r  <= scr_r;
      end
      default: begin
      end
    endcase
  end

  assign out_cell_char  = res_char_r;
  assign out_cell_attr  = res_attr_r;
  assign out_cursor_pos = res_pos_r;
  assign out_scrolled   = res_scr_r;

endmodule
`default_nettype wire

>>> hw/rtl/text_console_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with one screen store and one cursor per
// terminal: put character, read cell and clear shown terminal.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   cmd, ch, target_terminal, cell_index
//   out      output     out_valid / out_stall cell_char, cell_attr, cursor_pos, scrolled
//   cfg      input      cfg_we                cfg_idx, cfg_wdata
//
// One item at a time. A scroll copies the rows of the screen up by one, cell
// by cell, and blanks the bottom row; a clear blanks the shown terminal's
// screen cell by cell. After reset all TERMINALS*ROWS*COLUMNS cells of the
// store (6000 by default) are blanked one cell a cycle with in_stall high.
// A stalled result holds the block in its final step; the next item is
// accepted while an earlier result still waits.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TERMINALS = 3
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [tcw_pkg::CMD_W-1:0]       in_cmd,
  input  wire logic [tcw_pkg::CH_W-1:0]        in_ch,
  input  wire logic [tcw_pkg::TERM_W-1:0]      in_target_terminal,
  input  wire logic [tcw_pkg::IDX_W-1:0]       in_cell_index,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [tcw_pkg::CH_W-1:0]             out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]           out_cell_attr,
  output logic [tcw_pkg::POS_W-1:0]            out_cursor_pos,
  output logic                                 out_scrolled,
  input  wire logic                            cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  tcw_pkg::dp_cmd_t    dp_cmd;
  tcw_pkg::dp_status_t dp_st;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (dp_st),
    .cmd       (dp_cmd)
  );

  tcw_datapath #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TERMINALS (TERMINALS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (dp_cmd),
    .st                 (dp_st),
    .in_cmd             (in_cmd),
    .in_ch              (in_ch),
    .in_target_terminal (in_target_terminal),
    .in_cell_index      (in_cell_index),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_wdata          (cfg_wdata),
    .out_cell_char      (out_cell_char),
    .out_cell_attr      (out_cell_attr),
    .out_cursor_pos     (out_cursor_pos),
    .out_scrolled       (out_scrolled)
  );

endmodule
`default_nettype wire

>>> verif/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text console writer. A directed table covers
// the reset screen, bounds, backspace at home and the clear; random line,
// newline-burst, read, clear and noise sequences then run under several
// shown-terminal and attribute settings. Every result is checked field by
// field against the table's own value or an in-bench model of the screens
// and cursors, with random valid/stall bursts and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int TERMS  = 3;
  localparam int SCREEN = ROWS * COLS;
  localparam int RANDOM_ITEMS = 1800;
  localparam int PHASES = 8;
  localparam int HOLD_CYCLES = 400;
  // init sweep plus every item scrolling under the longest gaps, several times over
  localparam int CYCLE_LIMIT = 15_000_000;
  localparam logic [tcw_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [tcw_pkg::CH_W-1:0]   cell_char;
    logic [tcw_pkg::ATTR_W-1:0] cell_attr;
    logic [tcw_pkg::POS_W-1:0]  cursor_pos;
    logic                       scrolled;
  } console_result_t;

  typedef struct {
    logic [tcw_pkg::CMD_W-1:0]  cmd;
    logic [tcw_pkg::CH_W-1:0]   ch;
    logic [tcw_pkg::TERM_W-1:0] term;
    logic [tcw_pkg::IDX_W-1:0]  idx;
    bit                         typed;
    console_result_t            want;
  } probe_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [tcw_pkg::CMD_W-1:0] in_cmd;
  logic [tcw_pkg::CH_W-1:0] in_ch;
  logic [tcw_pkg::TERM_W-1:0] in_target_terminal;
  logic [tcw_pkg::IDX_W-1:0] in_cell_index;
  logic out_valid;
  logic out_stall;
  logic [tcw_pkg::CH_W-1:0] out_cell_char;
  logic [tcw_pkg::ATTR_W-1:0] out_cell_attr;
  logic [tcw_pkg::POS_W-1:0] out_cursor_pos;
  logic out_scrolled;
  logic cfg_we;
  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata;

  text_console_writer #(
    .COLUMNS(COLS),
    .ROWS(ROWS),
    .TERMINALS(TERMS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_ch(in_ch),
    .in_target_terminal(in_target_terminal),
    .in_cell_index(in_cell_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_cell_char(out_cell_char),
    .out_cell_attr(out_cell_attr),
    .out_cursor_pos(out_cursor_pos),
    .out_scrolled(out_scrolled),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // console model state
  logic [15:0] screen_mem [TERMS*SCREEN];
  int unsigned col_of [TERMS];
  int unsigned row_of [TERMS];
  logic [tcw_pkg::TERM_W-1:0] shown_term;
  logic [tcw_pkg::ATTR_W-1:0] attr_reg;

  console_result_t pending_results [$];
  probe_t probes [$];
  int mismatches;
  int results_seen;
  int items_offered;
  int idle_pct;
  bit quiet;
  bit pressure_done;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit line_feed(int t);
    int i;
    col_of[t] = 0;
    row_of[t]++;
    if (row_of[t] < ROWS) return 1'b0;
    for (i = 0; i < (ROWS - 1) * COLS; i++)
      screen_mem[t*SCREEN + i] = screen_mem[t*SCREEN + i + COLS];
    for (i = 0; i < COLS; i++)
      screen_mem[t*SCREEN + (ROWS - 1)*COLS + i] = {attr_reg, tcw_pkg::BLANK_CHAR};
    row_of[t] = ROWS - 1;
    return 1'b1;
  endfunction

  function automatic void back_step(int t);
    int a;
    if (col_of[t] == 0 && row_of[t] == 0) return;
    if (col_of[t] == 0) begin
      row_of[t]--;
      col_of[t] = COLS - 1;
    end else begin
      col_of[t]--;
    end
    a = t*SCREEN + row_of[t]*COLS + col_of[t];
    // attribute byte stays
    screen_mem[a][7:0] = tcw_pkg::BLANK_CHAR;
  endfunction

  function automatic bit print_byte(int t, logic [tcw_pkg::CH_W-1:0] c);
    bit sc;
    sc = 1'b0;
    if (c == tcw_pkg::CH_NUL) return 1'b0;
    if (c == tcw_pkg::CH_LF || c == tcw_pkg::CH_CR) return line_feed(t);
    if (c == tcw_pkg::CH_BS) begin
      back_step(t);
      return 1'b0;
    end
    if (col_of[t] >= COLS) sc = line_feed(t);
    screen_mem[t*SCREEN + row_of[t]*COLS + col_of[t]] = {attr_reg, c};
    col_of[t]++;
    return sc;
  endfunction

  function automatic console_result_t console_step(logic [tcw_pkg::CMD_W-1:0] cmd,
      logic [tcw_pkg::CH_W-1:0] c, logic [tcw_pkg::TERM_W-1:0] term,
      logic [tcw_pkg::IDX_W-1:0] idx);
    console_result_t res;
    logic [15:0] cell_word;
    int t, s, i;
    int unsigned pos;
    res = '0;
    t = term;
    s = shown_term;
    pos = 0;
    case (cmd)
      tcw_pkg::CMD_PUT: begin
        if (t < TERMS) res.scrolled = print_byte(t, c);
      end
      tcw_pkg::CMD_READ: begin
        if (t < TERMS && idx < SCREEN) begin
          cell_word = screen_mem[t*SCREEN + idx];
          res.cell_char = cell_word[7:0];
          res.cell_attr = cell_word[15:8];
        end
      end
      tcw_pkg::CMD_CLEAR: begin
        if (s < TERMS) begin
          col_of[s] = 0;
          row_of[s] = 0;
          for (i = 0; i < SCREEN; i++)
            screen_mem[s*SCREEN + i] = {attr_reg, tcw_pkg::BLANK_CHAR};
        end
      end
      default: ;
    endcase
    if (s < TERMS) pos = row_of[s]*COLS + col_of[s];
    res.cursor_pos = pos[tcw_pkg::POS_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_v);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, exp_v);
    mismatches++;
  endtask

  task automatic add_probe(logic [tcw_pkg::CMD_W-1:0] cmd, logic [tcw_pkg::CH_W-1:0] c,
      logic [tcw_pkg::TERM_W-1:0] term, logic [tcw_pkg::IDX_W-1:0] idx, bit typed,
      logic [tcw_pkg::CH_W-1:0] w_char, logic [tcw_pkg::ATTR_W-1:0] w_attr,
      logic [tcw_pkg::POS_W-1:0] w_pos, logic w_scr);
    probe_t p;
    p.cmd = cmd;
    p.ch = c;
    p.term = term;
    p.idx = idx;
    p.typed = typed;
    p.want = '{w_char, w_attr, w_pos, w_scr};
    probes.push_back(p);
  endtask

  task automatic offer_item(logic [tcw_pkg::CMD_W-1:0] cmd, logic [tcw_pkg::CH_W-1:0] c,
      logic [tcw_pkg::TERM_W-1:0] term, logic [tcw_pkg::IDX_W-1:0] idx, bit typed,
      console_result_t want);
    console_result_t predicted;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = cmd;
    in_ch = c;
    in_target_terminal = term;
    in_cell_index = idx;
    do @(posedge clk); while (in_stall);
    predicted = console_step(cmd, c, term, idx);
    pending_results.push_back(typed ? want : predicted);
    items_offered++;
  endtask

  task automatic write_registers(logic [tcw_pkg::TERM_W-1:0] shown,
      logic [tcw_pkg::ATTR_W-1:0] attr);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = tcw_pkg::REG_SHOWN;
    cfg_wdata = {{(tcw_pkg::CFG_DATA_W-tcw_pkg::TERM_W){1'b0}}, shown};
    @(negedge clk);
    cfg_idx = tcw_pkg::REG_ATTR;
    cfg_wdata = attr;
    @(negedge clk);
    cfg_we = 1'b0;
    shown_term = shown;
    attr_reg = attr;
  endtask

  function automatic logic [tcw_pkg::TERM_W-1:0] pick_term();
    return ($urandom_range(0, 11) == 0) ? 2'd3 : 2'($urandom_range(0, TERMS - 1));
  endfunction

  function automatic logic [tcw_pkg::CH_W-1:0] text_byte();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [tcw_pkg::IDX_W-1:0] read_index();
    return ($urandom_range(0, 9) == 0) ? 11'($urandom_range(SCREEN, 2047))
                                       : 11'($urandom_range(0, SCREEN - 1));
  endfunction

  task automatic run_phase(int quota);
    int start, kind, len, k;
    logic [tcw_pkg::TERM_W-1:0] t;
    start = items_offered;
    while (items_offered - start < quota) begin
      kind = $urandom_range(0, 99);
      t = pick_term();
      if (kind < 55) begin
        // a line of text, usually closed by a newline or backspaces
        len = ($urandom_range(0, 9) == 0) ? COLS : $urandom_range(0, 100);
        for (k = 0; k < len; k++)
          offer_item(tcw_pkg::CMD_PUT, text_byte(), t, 11'($urandom_range(0, 2047)),
                     1'b0, '0);
        k = $urandom_range(0, 99);
        if (k < 65)
          offer_item(tcw_pkg::CMD_PUT, $urandom_range(0, 1) ? tcw_pkg::CH_LF : tcw_pkg::CH_CR,
                     t, 11'($urandom_range(0, 2047)), 1'b0, '0);
        else if (k < 85)
          repeat ($urandom_range(1, 6))
            offer_item(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, t, 11'($urandom_range(0, 2047)),
                       1'b0, '0);
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 4))
          offer_item(tcw_pkg::CMD_READ, 8'($urandom_range(0, 255)), pick_term(),
                     read_index(), 1'b0, '0);
      end else if (kind < 89) begin
        offer_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   2'($urandom_range(0, 3)), 11'($urandom_range(0, 2047)), 1'b0, '0);
      end else if (kind < 97) begin
        // run of newlines to reach the bottom row and scroll
        repeat ($urandom_range(10, 30))
          offer_item(tcw_pkg::CMD_PUT, $urandom_range(0, 1) ? tcw_pkg::CH_LF : tcw_pkg::CH_CR,
                     2'($urandom_range(0, TERMS - 1)), 11'($urandom_range(0, 2047)),
                     1'b0, '0);
      end else begin
        offer_item(tcw_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                   11'($urandom_range(0, 2047)), 1'b0, '0);
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    console_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item cursor_pos", out_cursor_pos, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_cell_char !== want.cell_char)
          report_mismatch("cell_char", out_cell_char, want.cell_char);
        if (out_cell_attr !== want.cell_attr)
          report_mismatch("cell_attr", out_cell_attr, want.cell_attr);
        if (out_cursor_pos !== want.cursor_pos)
          report_mismatch("cursor_pos", out_cursor_pos, want.cursor_pos);
        if (out_scrolled !== want.scrolled)
          report_mismatch("scrolled", out_scrolled, want.scrolled);
      end
    end
  end

  // output stall bursts and one long hold-off
  initial begin
    int hold_count;
    out_stall = 1'b0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressure_done && !quiet && results_seen >= 150) begin
        out_stall = 1'b1;
        hold_count = 0;
        while (hold_count < HOLD_CYCLES) begin
          @(negedge clk);
          hold_count++;
        end
        pressure_done = 1'b1;
        out_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct / 3) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int i, ph;
    int shown_plan [PHASES];
    int attr_plan [PHASES];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = tcw_pkg::CMD_PUT;
    in_ch = tcw_pkg::CH_NUL;
    in_target_terminal = '0;
    in_cell_index = '0;
    cfg_we = 1'b0;
    cfg_idx = tcw_pkg::REG_SHOWN;
    cfg_wdata = '0;
    mismatches = 0;
    results_seen = 0;
    items_offered = 0;
    idle_pct = 20;
    quiet = 1'b0;
    for (i = 0; i < TERMS*SCREEN; i++)
      screen_mem[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
    for (i = 0; i < TERMS; i++) begin
      col_of[i] = 0;
      row_of[i] = 0;
    end
    shown_term = '0;
    attr_reg = tcw_pkg::RESET_ATTR;

    // reset screen, bounds, backspace and clear with shown 0 and attribute 7
    add_probe(tcw_pkg::CMD_READ, 8'h00, 2'd0, 11'd0, 1'b1,
              tcw_pkg::BLANK_CHAR, tcw_pkg::RESET_ATTR, 11'd0, 1'b0);
    add_probe(tcw_pkg::CMD_READ, 8'hff, 2'd2, 11'd1999, 1'b1,
              tcw_pkg::BLANK_CHAR, tcw_pkg::RESET_ATTR, 11'd0, 1'b0);
    add_probe(tcw_pkg::CMD_READ, 8'h00, 2'd0, 11'h7ff, 1'b1, 8'h00, 8'h00, 11'd0, 1'b0);
    add_probe(tcw_pkg::CMD_READ, 8'h00, 2'd3, 11'd0, 1'b1, 8'h00, 8'h00, 11'd0, 1'b0);
    add_probe(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, 2'd0, 11'd0, 1'b1,
              8'h00, 8'h00, 11'd0, 1'b0);
    add_probe(tcw_pkg::CMD_PUT, tcw_pkg::CH_NUL, 2'd0, 11'd0, 1'b1,
              8'h00, 8'h00, 11'd0, 1'b0);
    add_probe(tcw_pkg::CMD_PUT, 8'h41, 2'd0, 11'd0, 1'b1, 8'h00, 8'h00, 11'd1, 1'b0);
    add_probe(tcw_pkg::CMD_PUT, 8'hff, 2'd0, 11'd0, 1'b1, 8'h00, 8'h00, 11'd2, 1'b0);
    add_probe(tcw_pkg::CMD_READ, 8'h00, 2'd0, 11'd1, 1'b1,
              8'hff, tcw_pkg::RESET_ATTR, 11'd2, 1'b0);
    add_probe(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, 2'd0, 11'd0, 1'b1,
              8'h00, 8'h00, 11'd1, 1'b0);
    add_probe(tcw_pkg::CMD_READ, 8'h00, 2'd0, 11'd1, 1'b1,
              tcw_pkg::BLANK_CHAR, tcw_pkg::RESET_ATTR, 11'd1, 1'b0);
    add_probe(tcw_pkg::CMD_PUT, tcw_pkg::CH_LF, 2'd0, 11'd0, 1'b1,
              8'h00, 8'h00, 11'd80, 1'b0);
    add_probe(tcw_pkg::CMD_PUT, tcw_pkg::CH_CR, 2'd0, 11'd0, 1'b1,
              8'h00, 8'h00, 11'd160, 1'b0);
    add_probe(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, 2'd0, 11'd0, 1'b1,
              8'h00, 8'h00, 11'd159, 1'b0);
    add_probe(tcw_pkg::CMD_PUT, 8'h78, 2'd1, 11'd0, 1'b0, 8'h00, 8'h00, 11'd0, 1'b0);
    add_probe(tcw_pkg::CMD_PUT, 8'h7a, 2'd3, 11'd0, 1'b0, 8'h00, 8'h00, 11'd0, 1'b0);
    add_probe(CMD_UNUSED, 8'hff, 2'd3, 11'h7ff, 1'b0, 8'h00, 8'h00, 11'd0, 1'b0);
    add_probe(tcw_pkg::CMD_PUT, 8'h01, 2'd0, 11'h400, 1'b0, 8'h00, 8'h00, 11'd0, 1'b0);
    add_probe(tcw_pkg::CMD_READ, 8'h00, 2'd0, 11'd159, 1'b0, 8'h00, 8'h00, 11'd0, 1'b0);
    add_probe(tcw_pkg::CMD_CLEAR, 8'h55, 2'd1, 11'h2aa, 1'b1, 8'h00, 8'h00, 11'd0, 1'b0);
    add_probe(tcw_pkg::CMD_READ, 8'h00, 2'd0, 11'd0, 1'b1,
              tcw_pkg::BLANK_CHAR, tcw_pkg::RESET_ATTR, 11'd0, 1'b0);
    add_probe(tcw_pkg::CMD_READ, 8'h00, 2'd1, 11'd0, 1'b0, 8'h00, 8'h00, 11'd0, 1'b0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (probes[i])
      offer_item(probes[i].cmd, probes[i].ch, probes[i].term, probes[i].idx,
                 probes[i].typed, probes[i].want);

    shown_plan = '{0, 2, 3, 1, 2, 0, 1, 0};
    attr_plan  = '{255, 0, 0, 0, 255, 0, 7, 0};
    attr_plan[2] = $urandom_range(0, 255);
    attr_plan[3] = $urandom_range(0, 255);
    attr_plan[7] = $urandom_range(0, 255);

    for (ph = 0; ph < PHASES; ph++) begin
      write_registers(shown_plan[ph][tcw_pkg::TERM_W-1:0],
                      attr_plan[ph][tcw_pkg::ATTR_W-1:0]);
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      quiet = (ph == PHASES - 1);
      run_phase(RANDOM_ITEMS / PHASES);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
